/* sv/drs_pkg.sv */
// Shared types, constants and control structures for the drive relaxation scorer.
`timescale 1ns / 1ps

package drs_pkg;

    localparam int LEVEL_SLOTS = 5;
    localparam int IDX_W       = 3;
    localparam int Q16_W       = 16;
    localparam int SCORE_W     = 35;
    localparam int COUNT_W     = 16;
    localparam int MODE_W      = 2;
    localparam int DRIVE_W     = 3;
    localparam int DELTA_W     = 18;
    localparam int MS_W        = 16;
    localparam int WEIGHT_W    = 16;
    localparam int COEFF_W     = 13;
    localparam int QA_W        = 14;
    localparam int MUL_W       = 17;
    localparam int PROD_W      = 34;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_STIM   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELOAD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CAND   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY      = 3'd5;

    localparam logic [Q16_W-1:0] SETPOINT_RESET [LEVEL_SLOTS] =
        '{16'd39322, 16'd45875, 16'd32768, 16'd26214, 16'd52429};
    localparam logic [CFG_DATA_W-1:0] DECAY_RESET = 16'd2048;

    // Tick coefficient: floor(rate * ms / 1000), clamped to 1.0 in Q.12.
    localparam logic [COEFF_W-1:0] COEFF_ONE   = 13'd4096;
    localparam logic [31:0]        SAT_LIMIT   = 32'd4097000;
    localparam logic [QA_W-1:0]    RECIP_MUL   = 14'd8389;
    localparam int                 RECIP_SHIFT = 23;
    localparam logic [9:0]         MS_DIV      = 10'd1000;

    localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic             load;
        logic             stim;
        logic             reload;
        logic             rate_mul;
        logic             recip;
        logic             coeff;
        logic             drv_mul;
        logic             drv_upd;
        logic             cand_mul;
        logic             cand_acc;
        logic             best;
        logic             out_load;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] idx_prev;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

/* sv/drive_relaxation_scorer_core.sv */
// Top level of the drive relaxation scorer: controller plus datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   mode, drive, delta, elapsed_ms, weights, run_last
// output    out        o_out_valid / i_out_stall levels, score, best index/score/valid
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data (no read-back)
//
// One transaction is worked on at a time. With N = min(DRIVE_COUNT, 5) active drives,
// both the tick and the candidate score walk the N drives through one shared 17 x 17
// multiplier, one drive per cycle, with the update of the previous drive overlapped.
// The result sits in an output register, so a finished transaction waits there while the
// next one is accepted and computed; only the final load waits for a stalled output.
// Reset is synchronous and active low; it restores setpoints, rate, strengths and run state.

module drive_relaxation_scorer_core #(
    parameter int DRIVE_COUNT = 5
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [drs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [drs_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [drs_pkg::MODE_W-1:0]            i_mode,
    input  logic [drs_pkg::DRIVE_W-1:0]           i_drive,
    input  logic signed [drs_pkg::DELTA_W-1:0]    i_delta,
    input  logic [drs_pkg::MS_W-1:0]              i_elapsed_ms,
    input  logic signed [drs_pkg::WEIGHT_W-1:0]   i_weight_0,
    input  logic signed [drs_pkg::WEIGHT_W-1:0]   i_weight_1,
    input  logic signed [drs_pkg::WEIGHT_W-1:0]   i_weight_2,
    input  logic signed [drs_pkg::WEIGHT_W-1:0]   i_weight_3,
    input  logic signed [drs_pkg::WEIGHT_W-1:0]   i_weight_4,
    input  logic                                  i_run_last,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [drs_pkg::Q16_W-1:0]             o_level_0,
    output logic [drs_pkg::Q16_W-1:0]             o_level_1,
    output logic [drs_pkg::Q16_W-1:0]             o_level_2,
    output logic [drs_pkg::Q16_W-1:0]             o_level_3,
    output logic [drs_pkg::Q16_W-1:0]             o_level_4,
    output logic signed [drs_pkg::SCORE_W-1:0]    o_score,
    output logic [drs_pkg::COUNT_W-1:0]           o_best_index,
    output logic signed [drs_pkg::SCORE_W-1:0]    o_best_score,
    output logic                                  o_best_valid
);
    import drs_pkg::*;

    t_dp_cmd                   cmd;
    t_dp_stat                  stat;
    logic signed [WEIGHT_W-1:0] weight [LEVEL_SLOTS];
    logic [Q16_W-1:0]          level  [LEVEL_SLOTS];

    // Gather the weight ports into one vector for the datapath's drive walk.
    assign weight[0] = i_weight_0;
    assign weight[1] = i_weight_1;
    assign weight[2] = i_weight_2;
    assign weight[3] = i_weight_3;
    assign weight[4] = i_weight_4;

    // The controller only sequences; all values live in the datapath.
    drs_controller #(
        .DRIVE_COUNT (DRIVE_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    drs_datapath #(
        .DRIVE_COUNT (DRIVE_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_drive      (i_drive),
        .i_delta      (i_delta),
        .i_elapsed_ms (i_elapsed_ms),
        .i_weight     (weight),
        .i_run_last   (i_run_last),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_level      (level),
        .o_score      (o_score),
        .o_best_index (o_best_index),
        .o_best_score (o_best_score),
        .o_best_valid (o_best_valid)
    );

    // Spread the level vector back onto the individual result ports.
    assign o_level_0 = level[0];
    assign o_level_1 = level[1];
    assign o_level_2 = level[2];
    assign o_level_3 = level[3];
    assign o_level_4 = level[4];

endmodule

/* sv/drs_datapath.sv */
// Datapath: configuration, drive strengths, shared multiplier, run tracking and result register.
`timescale 1ns / 1ps

module drs_datapath #(
    parameter int DRIVE_COUNT = 5
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [drs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [drs_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [drs_pkg::DRIVE_W-1:0]           i_drive,
    input  logic signed [drs_pkg::DELTA_W-1:0]    i_delta,
    input  logic [drs_pkg::MS_W-1:0]              i_elapsed_ms,
    input  logic signed [drs_pkg::WEIGHT_W-1:0]   i_weight [drs_pkg::LEVEL_SLOTS],
    input  logic                                  i_run_last,
    input  drs_pkg::t_dp_cmd                      i_cmd,
    output drs_pkg::t_dp_stat                     o_stat,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic [drs_pkg::Q16_W-1:0]             o_level [drs_pkg::LEVEL_SLOTS],
    output logic signed [drs_pkg::SCORE_W-1:0]    o_score,
    output logic [drs_pkg::COUNT_W-1:0]           o_best_index,
    output logic signed [drs_pkg::SCORE_W-1:0]    o_best_score,
    output logic                                  o_best_valid
);
    import drs_pkg::*;

    localparam int NACT = (DRIVE_COUNT < LEVEL_SLOTS) ? DRIVE_COUNT : LEVEL_SLOTS;

    logic [Q16_W-1:0]             r_setpoint [NACT];
    logic [CFG_DATA_W-1:0]        r_rate;
    logic [DRIVE_W-1:0]           r_drive;
    logic signed [DELTA_W-1:0]    r_delta;
    logic [MS_W-1:0]              r_ms;
    logic signed [WEIGHT_W-1:0]   r_weight [NACT];
    logic                         r_last;
    logic [Q16_W-1:0]             r_strength [NACT];
    logic [Q16_W-1:0]             n_strength [NACT];
    logic signed [PROD_W-1:0]     r_prod;
    logic                         r_neg;
    logic                         r_sat;
    logic [QA_W-1:0]              r_qa;
    logic [COEFF_W-1:0]           r_coeff;
    logic signed [SCORE_W-1:0]    r_acc;
    logic [COUNT_W-1:0]           r_count;
    logic signed [SCORE_W-1:0]    r_run_best;
    logic [COUNT_W-1:0]           r_run_idx;
    logic [COUNT_W-1:0]           r_res_bidx;
    logic signed [SCORE_W-1:0]    r_res_bscore;
    logic                         r_res_bval;
    logic                         r_out_valid;
    logic [Q16_W-1:0]             r_out_level [LEVEL_SLOTS];
    logic signed [SCORE_W-1:0]    r_out_score;
    logic [COUNT_W-1:0]           r_out_bidx;
    logic signed [SCORE_W-1:0]    r_out_bscore;
    logic                         r_out_bval;

    logic [Q16_W-1:0]             sel_st;
    logic [Q16_W-1:0]             sel_sp;
    logic signed [WEIGHT_W-1:0]   sel_w;
    logic [Q16_W-1:0]             prev_st;
    logic [Q16_W-1:0]             stim_st;
    logic signed [MUL_W-1:0]      diff;
    logic signed [MUL_W-1:0]      diff_mag;
    logic signed [MUL_W-1:0]      mul_a;
    logic signed [MUL_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]     mul_p;
    logic [36:0]                  recip_full;
    logic [23:0]                  qa_back;
    logic                         qa_over;
    logic [Q16_W-1:0]             step;
    logic signed [17:0]           upd_sum;
    logic [Q16_W-1:0]             upd_sat;
    logic signed [18:0]           stim_sum;
    logic [Q16_W-1:0]             stim_sat;
    logic                         best_gt;
    logic signed [SCORE_W-1:0]    best_next;
    logic [COUNT_W-1:0]           bidx_next;
    logic [Q16_W-1:0]             level_now [LEVEL_SLOTS];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NACT; i++) begin
                r_setpoint[i] <= SETPOINT_RESET[i];
            end
            r_rate <= DECAY_RESET;
        end else if (i_cfg_we) begin
            for (int i = 0; i < NACT; i++) begin
                if (i_cfg_index == REG_SETPOINT_0 + CFG_IDX_W'(i)) begin
                    r_setpoint[i] <= i_cfg_data;
                end
            end
            if (i_cfg_index == REG_DECAY) begin
                r_rate <= i_cfg_data;
            end
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_drive <= i_drive;
            r_delta <= i_delta;
            r_ms    <= i_elapsed_ms;
            r_last  <= i_run_last;
            for (int i = 0; i < NACT; i++) begin
                r_weight[i] <= i_weight[i];
            end
        end
    end

    // Element selection for the sequenced loops.
    always_comb begin
        sel_st  = '0;
        sel_sp  = '0;
        sel_w   = '0;
        prev_st = '0;
        stim_st = '0;
        for (int i = 0; i < NACT; i++) begin
            if (i_cmd.idx == IDX_W'(i)) begin
                sel_st = r_strength[i];
                sel_sp = r_setpoint[i];
                sel_w  = r_weight[i];
            end
            if (i_cmd.idx_prev == IDX_W'(i)) begin
                prev_st = r_strength[i];
            end
            if (r_drive == DRIVE_W'(i)) begin
                stim_st = r_strength[i];
            end
        end
    end

    assign diff     = $signed({1'b0, sel_sp}) - $signed({1'b0, sel_st});
    assign diff_mag = diff[MUL_W-1] ? -diff : diff;

    // The one shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.rate_mul) begin
            mul_a = $signed({1'b0, r_rate});
            mul_b = $signed({1'b0, r_ms});
        end else if (i_cmd.drv_mul) begin
            mul_a = $signed({4'b0000, r_coeff});
            mul_b = diff_mag;
        end else if (i_cmd.cand_mul) begin
            mul_a = $signed({1'b0, sel_st});
            mul_b = {sel_w[WEIGHT_W-1], sel_w};
        end
    end

    assign mul_p = mul_a * mul_b;

    // Division by 1000 through a reciprocal, then a single correction.
    assign recip_full = 37'(r_prod[22:0]) * 37'(RECIP_MUL);
    assign qa_back    = 24'(r_qa) * 24'(MS_DIV);
    assign qa_over    = qa_back > {1'b0, r_prod[22:0]};

    // Relaxation step, truncated toward zero.
    assign step    = r_prod[27:12];
    assign upd_sum = r_neg ? ($signed({2'b00, prev_st}) - $signed({2'b00, step}))
                           : ($signed({2'b00, prev_st}) + $signed({2'b00, step}));
    always_comb begin
        if (upd_sum[17]) begin
            upd_sat = '0;
        end else if (upd_sum[16]) begin
            upd_sat = '1;
        end else begin
            upd_sat = upd_sum[15:0];
        end
    end

    assign stim_sum = $signed({3'b000, stim_st}) + 19'(r_delta);
    always_comb begin
        if (stim_sum[18]) begin
            stim_sat = '0;
        end else if (stim_sum[17] || stim_sum[16]) begin
            stim_sat = '1;
        end else begin
            stim_sat = stim_sum[15:0];
        end
    end

    always_comb begin
        for (int i = 0; i < NACT; i++) begin
            n_strength[i] = r_strength[i];
            if (i_cmd.stim && r_drive == DRIVE_W'(i)) begin
                n_strength[i] = stim_sat;
            end
            if (i_cmd.reload) begin
                n_strength[i] = r_setpoint[i];
            end
            if (i_cmd.drv_upd && i_cmd.idx_prev == IDX_W'(i)) begin
                n_strength[i] = upd_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NACT; i++) begin
                r_strength[i] <= SETPOINT_RESET[i];
            end
        end else begin
            for (int i = 0; i < NACT; i++) begin
                r_strength[i] <= n_strength[i];
            end
        end
    end

    // Tick arithmetic and score accumulation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rate_mul || i_cmd.drv_mul || i_cmd.cand_mul) begin
            r_prod <= mul_p;
        end
        if (i_cmd.drv_mul) begin
            r_neg <= diff[MUL_W-1];
        end
        if (i_cmd.recip) begin
            r_sat <= r_prod[31:0] >= SAT_LIMIT;
            r_qa  <= recip_full[36:RECIP_SHIFT];
        end
        if (i_cmd.coeff) begin
            if (r_sat) begin
                r_coeff <= COEFF_ONE;
            end else if (qa_over) begin
                r_coeff <= COEFF_W'(r_qa - 14'd1);
            end else begin
                r_coeff <= COEFF_W'(r_qa);
            end
        end
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (i_cmd.cand_acc) begin
            r_acc <= r_acc + SCORE_W'(r_prod);
        end
    end

    // Running argmax; strictly greater, so the first of equal scores stays.
    assign best_gt   = r_acc > r_run_best;
    assign best_next = best_gt ? r_acc : r_run_best;
    assign bidx_next = best_gt ? r_count : r_run_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_run_best   <= SCORE_MIN;
            r_run_idx    <= '0;
            r_res_bval   <= 1'b0;
            r_res_bidx   <= '0;
            r_res_bscore <= '0;
        end else if (i_cmd.load) begin
            r_res_bval   <= 1'b0;
            r_res_bidx   <= '0;
            r_res_bscore <= '0;
        end else if (i_cmd.best) begin
            if (r_last) begin
                r_res_bval   <= 1'b1;
                r_res_bidx   <= bidx_next;
                r_res_bscore <= best_next;
                r_count      <= '0;
                r_run_best   <= SCORE_MIN;
                r_run_idx    <= '0;
            end else begin
                r_run_best <= best_next;
                r_run_idx  <= bidx_next;
                if (r_count != COUNT_MAX) begin
                    r_count <= r_count + 16'd1;
                end
            end
        end
    end

    // Drives beyond the active count hold their reset setpoints.
    genvar g;
    for (g = 0; g < LEVEL_SLOTS; g++) begin : g_level
        if (g < NACT) begin : g_act
            assign level_now[g] = r_strength[g];
        end else begin : g_fixed
            assign level_now[g] = SETPOINT_RESET[g];
        end
    end

    // Output register.
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int i = 0; i < LEVEL_SLOTS; i++) begin
                r_out_level[i] <= level_now[i];
            end
            r_out_score  <= r_acc;
            r_out_bidx   <= r_res_bidx;
            r_out_bscore <= r_res_bscore;
            r_out_bval   <= r_res_bval;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_level      = r_out_level;
    assign o_score      = r_out_score;
    assign o_best_index = r_out_bidx;
    assign o_best_score = r_out_bscore;
    assign o_best_valid = r_out_bval;

endmodule

/* sv/drs_controller.sv */
// Controller state machine that sequences each item through the datapath.
`timescale 1ns / 1ps

module drs_controller #(
    parameter int DRIVE_COUNT = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [drs_pkg::MODE_W-1:0]  i_mode,
    input  drs_pkg::t_dp_stat           i_stat,
    output drs_pkg::t_dp_cmd            o_cmd
);
    import drs_pkg::*;

    localparam int NACT = (DRIVE_COUNT < LEVEL_SLOTS) ? DRIVE_COUNT : LEVEL_SLOTS;
    localparam logic [IDX_W-1:0] LOOP_END = IDX_W'(NACT);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_STIM   = 4'd1;
    localparam logic [3:0] S_RELOAD = 4'd2;
    localparam logic [3:0] S_RATE   = 4'd3;
    localparam logic [3:0] S_RECIP  = 4'd4;
    localparam logic [3:0] S_COEFF  = 4'd5;
    localparam logic [3:0] S_DRIVE  = 4'd6;
    localparam logic [3:0] S_CAND   = 4'd7;
    localparam logic [3:0] S_BEST   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] n_cnt;
    logic             accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        n_cnt          = '0;
        o_cmd          = '0;
        o_cmd.idx      = r_cnt;
        o_cmd.idx_prev = r_cnt - 3'd1;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = accept;
                if (accept) begin
                    case (i_mode)
                        MODE_STIM:   n_state = S_STIM;
                        MODE_TICK:   n_state = S_RATE;
                        MODE_RELOAD: n_state = S_RELOAD;
                        MODE_CAND:   n_state = S_CAND;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_STIM: begin
                o_cmd.stim = 1'b1;
                n_state    = S_OUT;
            end
            S_RELOAD: begin
                o_cmd.reload = 1'b1;
                n_state      = S_OUT;
            end
            S_RATE: begin
                o_cmd.rate_mul = 1'b1;
                n_state        = S_RECIP;
            end
            S_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state     = S_COEFF;
            end
            S_COEFF: begin
                o_cmd.coeff = 1'b1;
                n_state     = S_DRIVE;
            end
            S_DRIVE: begin
                o_cmd.drv_mul = (r_cnt != LOOP_END);
                o_cmd.drv_upd = (r_cnt != '0);
                if (r_cnt == LOOP_END) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_CAND: begin
                o_cmd.cand_mul = (r_cnt != LOOP_END);
                o_cmd.cand_acc = (r_cnt != '0);
                if (r_cnt == LOOP_END) begin
                    n_state = S_BEST;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_BEST: begin
                o_cmd.best = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
